/* rtl/sem_pkg.sv */
// Shared types and constants for the Sobel edge magnitude unit.
package sem_pkg;

	localparam int PIX_W        = 8;
	localparam int IMG_W_REG_W  = 12;
	localparam int IMG_H_REG_W  = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_IDX_W    = 1;
	localparam int MIN_DIM      = 3;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int GRAD_W       = 11;
	localparam int MAG_W        = 10;
	localparam int SQ_W         = 20;
	localparam int SUM_W        = 21;
	localparam int RAD_W        = 16;
	localparam int REM_W        = 10;
	localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65025;
	localparam logic [PIX_W-1:0] EDGE_MAX  = 8'd255;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// per-result flags travelling with an item down the pipeline
	typedef struct packed {
		logic interior;
		logic last;
	} res_ctl_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [PIX_W-1:0] root;
	} sqrt_part_t;

	// four digits of a restoring square root, two radicand bits per digit
	function automatic sqrt_part_t sqrt_4_digits(sqrt_part_t start, logic [7:0] bits);
		sqrt_part_t       p;
		logic [11:0]      acc;
		logic [11:0]      trial;
		p = start;
		for (int i = 0; i < 4; i++) begin
			acc   = {p.rem, bits[7-2*i -: 2]};
			trial = {2'b00, p.root, 2'b01};
			if (acc >= trial) begin
				p.rem  = REM_W'(acc - trial);
				p.root = {p.root[PIX_W-2:0], 1'b1};
			end else begin
				p.rem  = acc[REM_W-1:0];
				p.root = {p.root[PIX_W-2:0], 1'b0};
			end
		end
		return p;
	endfunction

endpackage

/* rtl/sobel_edge_magnitude_unit.sv */
// Top level: streaming 3x3 Sobel gradient magnitude over a raster pixel stream.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, mode, pixel_in   | sink
//  out     | out_valid, out_ready, edge_value,    | source
//          | frame_last                           |
//  cfg     | cfg_we, cfg_index, cfg_data          | sink
//
// One item transfer per cycle while no result waits untaken; a result leaves the output register after
// the transfer of the item that causes it (RAM read, gradient, square, sum, two root stages).
// The two line stores are single-port-write RAMs; a column is read on transfer and written back from stage 1.
// Reset clears counters, window and valid bits; line store contents are not cleared.
// An untaken result freezes the whole pipeline and holds in_ready low.
module sobel_edge_magnitude_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [sem_pkg::PIX_W-1:0]        pixel_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sem_pkg::PIX_W-1:0]        edge_value,
	output logic                             frame_last,
	input  logic                             cfg_we,
	input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import sem_pkg::*;

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int WD_W  = $clog2(MAX_WIDTH + 2);
	localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
	localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

	// dimensions, held as last index
	logic [WD_W-1:0] wm1_q, wm1_next;
	logic [HT_W-1:0] hm1_q, hm1_next;
	logic [IMG_W_REG_W-1:0] w_raw;
	logic [IMG_H_REG_W-1:0] h_raw;

	logic [WD_W-1:0] in_col_q, out_col_q, pending_q;
	logic [HT_W-1:0] in_row_q, out_row_q;

	logic     en, accept, is_drain, fire_px, emit, interior_pos, last_pos;
	res_ctl_t ctl_in;

	// stage 1: line store data returns
	logic             v_s1, pix_s1, emit_s1;
	logic [PIX_W-1:0] px_s1;
	logic [AW-1:0]    col_s1;
	res_ctl_t         ctl_s1;
	logic [PIX_W-1:0] up_rd, mid_rd;
	logic [PIX_W-1:0] win0_q [3];
	logic [PIX_W-1:0] win1_q [3];
	logic [MAG_W-1:0] sum_xa, sum_xb, sum_ya, sum_yb, mag_x, mag_y;
	logic [GRAD_W-1:0] gx, gy;
	logic             ram_we, ram_re;

	// later stages
	logic             v_s2, v_s3, v_s4, v_s5;
	res_ctl_t         ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [MAG_W-1:0] ax_s2, ay_s2;
	logic [SQ_W-1:0]  sqx_s3, sqy_s3;
	logic [SUM_W-1:0] sum_s3;
	logic             sat_s4, sat_s5;
	logic [RAD_W-1:0] rad_s4;
	logic [7:0]       rad_lo_s5;
	sqrt_part_t       part_a, part_s5, part_b;

	logic             out_valid_q, last_q;
	logic [PIX_W-1:0] edge_q;

	// ---------------- configuration ----------------
	always_comb begin
		w_raw = cfg_data[IMG_W_REG_W-1:0];
		h_raw = cfg_data[IMG_H_REG_W-1:0];
		if (w_raw < IMG_W_REG_W'(MIN_DIM)) begin
			wm1_next = WD_W'(MIN_DIM - 1);
		end else if (32'(w_raw) > MAX_WIDTH) begin
			wm1_next = WD_W'(MAX_WIDTH - 1);
		end else begin
			wm1_next = WD_W'(32'(w_raw) - 1);
		end
		if (h_raw < IMG_H_REG_W'(MIN_DIM)) begin
			hm1_next = HT_W'(MIN_DIM - 1);
		end else if (32'(h_raw) > MAX_HEIGHT) begin
			hm1_next = HT_W'(MAX_HEIGHT - 1);
		end else begin
			hm1_next = HT_W'(32'(h_raw) - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= WD_W'(RST_W - 1);
			hm1_q <= HT_W'(RST_H - 1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  wm1_q <= wm1_next;
				REG_IMAGE_HEIGHT: hm1_q <= hm1_next;
				default: ;
			endcase
		end
	end

	// ---------------- transfer and position tracking ----------------
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && en;

	always_comb begin
		is_drain     = (mode == MODE_DRAIN);
		fire_px      = (pending_q == wm1_q + WD_W'(2));
		emit         = is_drain ? (pending_q != '0) : fire_px;
		interior_pos = (out_col_q != '0) && (out_col_q != wm1_q) &&
		               (out_row_q != '0) && (out_row_q != hm1_q);
		last_pos     = (out_col_q == wm1_q) && (out_row_q == hm1_q);
		ctl_in       = '{interior: !is_drain && interior_pos, last: last_pos};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else if (cfg_we) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else if (accept) begin
			if (!is_drain) begin
				if (in_col_q == wm1_q) begin
					in_col_q <= '0;
					in_row_q <= (in_row_q == hm1_q) ? '0 : in_row_q + HT_W'(1);
				end else begin
					in_col_q <= in_col_q + WD_W'(1);
				end
			end
			if (emit) begin
				if (out_col_q == wm1_q) begin
					out_col_q <= '0;
					out_row_q <= (out_row_q == hm1_q) ? '0 : out_row_q + HT_W'(1);
				end else begin
					out_col_q <= out_col_q + WD_W'(1);
				end
			end
			if (is_drain && emit) begin
				pending_q <= pending_q - WD_W'(1);
			end else if (!is_drain && !fire_px) begin
				pending_q <= pending_q + WD_W'(1);
			end
		end
	end

	// ---------------- line stores ----------------
	assign ram_re = accept && !is_drain;
	assign ram_we = en && v_s1 && pix_s1;

	sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (mid_rd),
		.re    (ram_re),
		.raddr (in_col_q[AW-1:0]),
		.rdata (up_rd)
	);

	sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (px_s1),
		.re    (ram_re),
		.raddr (in_col_q[AW-1:0]),
		.rdata (mid_rd)
	);

	// ---------------- gradients ----------------
	always_comb begin
		sum_xa = MAG_W'(up_rd) + {1'b0, mid_rd, 1'b0} + MAG_W'(px_s1);
		sum_xb = MAG_W'(win0_q[0]) + {1'b0, win0_q[1], 1'b0} + MAG_W'(win0_q[2]);
		sum_ya = MAG_W'(win0_q[2]) + {1'b0, win1_q[2], 1'b0} + MAG_W'(px_s1);
		sum_yb = MAG_W'(win0_q[0]) + {1'b0, win1_q[0], 1'b0} + MAG_W'(up_rd);
		gx     = {1'b0, sum_xa} - {1'b0, sum_xb};
		gy     = {1'b0, sum_ya} - {1'b0, sum_yb};
		mag_x  = gx[GRAD_W-1] ? MAG_W'(-gx) : gx[MAG_W-1:0];
		mag_y  = gy[GRAD_W-1] ? MAG_W'(-gy) : gy[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win0_q[i] <= '0;
				win1_q[i] <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < 3; i++) begin
				win0_q[i] <= '0;
				win1_q[i] <= '0;
			end
		end else if (ram_we) begin
			for (int i = 0; i < 3; i++) begin
				win0_q[i] <= win1_q[i];
			end
			win1_q[0] <= up_rd;
			win1_q[1] <= mid_rd;
			win1_q[2] <= px_s1;
		end
	end

	// ---------------- root digits ----------------
	assign part_a = sqrt_4_digits('{rem: '0, root: '0}, rad_s4[RAD_W-1:8]);
	assign part_b = sqrt_4_digits(part_s5, rad_lo_s5);

	// ---------------- pipeline valids ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= accept;
			v_s2        <= v_s1 && emit_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// ---------------- pipeline payload ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1    <= !is_drain;
			emit_s1   <= emit;
			px_s1     <= pixel_in;
			col_s1    <= in_col_q[AW-1:0];
			ctl_s1    <= ctl_in;

			ax_s2     <= mag_x;
			ay_s2     <= mag_y;
			ctl_s2    <= ctl_s1;

			sqx_s3    <= SQ_W'(ax_s2) * SQ_W'(ax_s2);
			sqy_s3    <= SQ_W'(ay_s2) * SQ_W'(ay_s2);
			ctl_s3    <= ctl_s2;

			sat_s4    <= (sum_s3 >= SAT_LIMIT);
			rad_s4    <= sum_s3[RAD_W-1:0];
			ctl_s4    <= ctl_s3;

			part_s5   <= part_a;
			rad_lo_s5 <= rad_s4[7:0];
			sat_s5    <= sat_s4;
			ctl_s5    <= ctl_s4;

			last_q    <= ctl_s5.last;
			if (!ctl_s5.interior) begin
				edge_q <= '0;
			end else if (sat_s5) begin
				edge_q <= EDGE_MAX;
			end else begin
				edge_q <= part_b.root;
			end
		end
	end

	assign sum_s3 = SUM_W'(sqx_s3) + SUM_W'(sqy_s3);

	assign out_valid  = out_valid_q;
	assign edge_value = edge_q;
	assign frame_last = last_q;

`ifndef SYNTH
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= wm1_q + WD_W'(2))
		else $error("pending count beyond line delay");

	a_in_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_col_q <= wm1_q && out_col_q <= wm1_q)
		else $error("column counter beyond row width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= hm1_q && out_row_q <= hm1_q)
		else $error("row counter beyond frame height");
`endif

endmodule

/* rtl/sem_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* dv/sem_tb_pkg.sv */
// Scoreboard for the Sobel edge magnitude unit: pixel-stream predictor and result checker.
package sem_tb_pkg;

	import sem_pkg::*;

	localparam int LINE_DEPTH  = 2048;
	localparam int HEIGHT_CAP  = 4096;
	localparam int REPORT_MAX  = 10;

	typedef struct {
		logic [PIX_W-1:0] edge_val;
		logic             last;
	} edge_result_t;

	class edge_scoreboard;
		logic [IMG_W_REG_W-1:0] width_reg;
		logic [IMG_H_REG_W-1:0] height_reg;
		logic [PIX_W-1:0]       upper_line [LINE_DEPTH];
		logic [PIX_W-1:0]       middle_line [LINE_DEPTH];
		logic [PIX_W-1:0]       win [2][3];
		int unsigned            in_col, in_row, out_col, out_row, backlog;
		edge_result_t           expected_q [$];
		int unsigned            errors;

		function new();
			width_reg  = IMG_W_REG_W'(RESET_WIDTH);
			height_reg = IMG_H_REG_W'(RESET_HEIGHT);
			errors     = 0;
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			restart_frame();
		endfunction

		function int unsigned eff_width();
			int unsigned w;
			w = width_reg;
			if (w < MIN_DIM) w = MIN_DIM;
			if (w > LINE_DEPTH) w = LINE_DEPTH;
			return w;
		endfunction

		function int unsigned eff_height();
			int unsigned h;
			h = height_reg;
			if (h < MIN_DIM) h = MIN_DIM;
			if (h > HEIGHT_CAP) h = HEIGHT_CAP;
			return h;
		endfunction

		function void restart_frame();
			foreach (win[i, j]) win[i][j] = '0;
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
			backlog = 0;
		endfunction

		// any register write restarts the frame, line stores are kept
		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH: width_reg = data[IMG_W_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_reg = data[IMG_H_REG_W-1:0];
			endcase
			restart_frame();
		endfunction

		function void step_pos(inout int unsigned col, inout int unsigned row,
			input int unsigned w, input int unsigned h);
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function logic [PIX_W-1:0] root_sat(int unsigned s);
			int unsigned r;
			if (s >= SAT_LIMIT) return EDGE_MAX;
			r = 0;
			for (int unsigned b = 128; b != 0; b = b >> 1) begin
				if ((r | b) * (r | b) <= s) r = r | b;
			end
			return r[PIX_W-1:0];
		endfunction

		function void push_result(logic [PIX_W-1:0] v, int unsigned w, int unsigned h);
			edge_result_t res;
			res.edge_val = v;
			res.last     = (out_col == w - 1) && (out_row == h - 1);
			expected_q.push_back(res);
			step_pos(out_col, out_row, w, h);
		endfunction

		function void note_input(logic m, logic [PIX_W-1:0] px);
			int unsigned      w, h, c, sq;
			logic [PIX_W-1:0] col_new [3];
			int               gx, gy;
			logic [PIX_W-1:0] mag;
			w = eff_width();
			h = eff_height();
			if (m == MODE_DRAIN) begin
				if (backlog != 0) begin
					backlog--;
					push_result('0, w, h);
				end
				return;
			end
			c = in_col % LINE_DEPTH;
			col_new[0] = upper_line[c];
			col_new[1] = middle_line[c];
			col_new[2] = px;
			gx = (int'(col_new[0]) + 2 * int'(col_new[1]) + int'(col_new[2]))
				- (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
			gy = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(col_new[2]))
				- (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(col_new[0]));
			upper_line[c]  = col_new[1];
			middle_line[c] = px;
			for (int k = 0; k < 3; k++) begin
				win[0][k] = win[1][k];
				win[1][k] = col_new[k];
			end
			step_pos(in_col, in_row, w, h);
			if (backlog < w + 1) begin
				backlog++;
				return;
			end
			mag = '0;
			if (out_col >= 1 && out_col + 1 < w && out_row >= 1 && out_row + 1 < h) begin
				sq  = unsigned'(gx * gx + gy * gy);
				mag = root_sat(sq);
			end
			push_result(mag, w, h);
		endfunction

		function int unsigned outstanding();
			return expected_q.size();
		endfunction

		function void check_result(logic [PIX_W-1:0] ev, logic fl);
			edge_result_t exp_r;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result: edge_value=%0d frame_last=%0b", ev, fl);
				return;
			end
			exp_r = expected_q.pop_front();
			if (ev !== exp_r.edge_val || fl !== exp_r.last) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("mismatch: edge_value exp %0d got %0d, frame_last exp %0b got %0b",
						exp_r.edge_val, ev, exp_r.last, fl);
			end
		endfunction
	endclass

endpackage

/* dv/tb_top.sv */
// Top-level testbench for the Sobel edge magnitude unit: stimulus, handshakes and checking.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sem_pkg::*;
	import sem_tb_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_ITEMS = 1200;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  mode;
	logic [PIX_W-1:0]      pixel_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [PIX_W-1:0]      edge_value;
	logic                  frame_last;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	edge_scoreboard sb = new();
	bit             calm;
	int unsigned    hold_reqs;
	int unsigned    stall_cycles;

	// two 3x3 frames back to back: saturating vertical edge, then a mixed one
	logic [PIX_W-1:0] directed_px [18] = '{
		8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd128, 8'd7, 8'd1, 8'd0, 8'd0, 8'd0
	};

	sobel_edge_magnitude_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.edge_value (edge_value),
		.frame_last (frame_last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: short random back-pressure, one long hold on request
	initial begin
		int unsigned hold_left, gap_left, hold_done;
		hold_left = 0;
		gap_left  = 0;
		hold_done = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != hold_done) begin
				hold_done = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (gap_left != 0) begin
				out_ready <= 1'b0;
				gap_left--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				gap_left = $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(edge_value, frame_last);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_item(logic m, logic [PIX_W-1:0] px);
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		pixel_in <= px;
		do @(posedge clk); while (!in_ready);
		sb.note_input(m, px);
	endtask

	// stop sending and let every result and any in-flight item clear
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		settle();
		if ($urandom_range(0, 1)) begin
			cfg_write(REG_IMAGE_WIDTH, w);
			cfg_write(REG_IMAGE_HEIGHT, h);
		end else begin
			cfg_write(REG_IMAGE_HEIGHT, h);
			cfg_write(REG_IMAGE_WIDTH, w);
		end
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel(int unsigned style);
		case (style)
			0: return PIX_W'($urandom_range(0, 255));
			1: return $urandom_range(0, 1) ? EDGE_MAX : '0;
			default: return PIX_W'($urandom_range(96, 160));
		endcase
	endfunction

	initial begin
		int unsigned w, h, ew, eh, n, tail, style, drain_pct, phase, random_items;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		mode          = MODE_PIXEL;
		pixel_in      = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_IMAGE_WIDTH;
		cfg_data      = '0;
		calm          = 1'b0;
		hold_reqs     = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty drain, reset geometry, clamped minimum frame, tail drain
		send_item(MODE_DRAIN, '0);
		send_item(MODE_PIXEL, 8'd77);
		set_frame(13'd1, 13'd2);
		foreach (directed_px[i]) send_item(MODE_PIXEL, directed_px[i]);
		repeat (5) send_item(MODE_DRAIN, '0);

		phase        = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (phase == 2) begin
				w = 4095;
				h = 3;
			end else if (phase == 3) begin
				w = 5;
				h = 4;
			end else begin
				w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(3, 24);
				case ($urandom_range(0, 11))
					0: h = 8191;
					1: h = $urandom_range(0, 2);
					2: h = 4096;
					default: h = $urandom_range(3, 8);
				endcase
			end
			ew = (w < MIN_DIM) ? MIN_DIM : ((w > LINE_DEPTH) ? LINE_DEPTH : w);
			eh = (h < MIN_DIM) ? MIN_DIM : ((h > HEIGHT_CAP) ? HEIGHT_CAP : h);
			if (phase == 2) begin
				n    = 60;
				tail = 20;
			end else begin
				n = $urandom_range(ew * eh / 2, ew * eh * 3) + ew + 1;
				if (n > 400) n = 400;
				if (phase == 3) n = 80;
				tail = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ew + 3) : ew + 2;
			end
			// width register ignores the top data bit
			set_frame(CFG_DATA_W'(w) | (CFG_DATA_W'($urandom_range(0, 1)) << IMG_W_REG_W),
				CFG_DATA_W'(h));
			style     = $urandom_range(0, 2);
			drain_pct = ($urandom_range(0, 3) == 0) ? 4 : 0;
			for (int i = 0; i < n; i++) begin
				if (phase == 3 && i == 10) hold_reqs++;
				if ($urandom_range(0, 99) < drain_pct)
					send_item(MODE_DRAIN, '0);
				else
					send_item(MODE_PIXEL, pick_pixel(style));
			end
			repeat (tail) send_item(MODE_DRAIN, '0);
			random_items += n + tail;
			if (random_items > RANDOM_ITEMS - 200) calm = 1'b1;
			phase++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sobel_edge_magnitude_unit.sv
dv/sem_tb_pkg.sv
dv/tb_top.sv
